/* hw/rtl/acri_pkg.sv */
// shared constants and types of the colour ramp interpolator
package acri_pkg;

	localparam int CH_N          = 4;
	localparam int CH_W          = 8;
	localparam int COLOUR_W      = CH_N * CH_W;
	localparam int SPAN_BITS_DEF = 16;
	localparam int DIV_STEPS     = 4;

	// data that rides alongside the divider lanes
	typedef struct packed {
		logic [COLOUR_W-1:0] colour_start;
		logic [CH_N-1:0]     neg;
		logic                span_zero;
	} side_t;

endpackage

/* hw/rtl/acri_in_if.sv */
// request channel of the colour ramp interpolator
interface acri_in_if #(
	parameter int SPAN_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [31:0]          colour_start;
	logic [31:0]          colour_end;
	logic [SPAN_BITS-1:0] span_length;
	logic [SPAN_BITS-1:0] step_index;

	modport source (output valid, colour_start, colour_end, span_length, step_index,
		input ready);
	modport sink (input valid, colour_start, colour_end, span_length, step_index,
		output ready);
endinterface

/* hw/rtl/acri_out_if.sv */
// result channel of the colour ramp interpolator
interface acri_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] colour_out;

	modport source (output valid, colour_out, input ready);
	modport sink (input valid, colour_out, output ready);
endinterface

/* hw/rtl/acri_front.sv */
// front stages: per-channel difference, then magnitude of difference times step
module acri_front import acri_pkg::*; #(
	parameter int SPAN_BITS = SPAN_BITS_DEF,
	localparam int DW = CH_W + SPAN_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  logic [COLOUR_W-1:0]  colour_start,
	input  logic [COLOUR_W-1:0]  colour_end,
	input  logic [SPAN_BITS-1:0] span_length,
	input  logic [SPAN_BITS-1:0] step_index,
	output logic                 valid_s2,
	output side_t                side_s2,
	output logic [SPAN_BITS-1:0] span_s2,
	output logic [DW-1:0]        mag_s2 [CH_N]
);

	logic                 valid_s1;
	side_t                side_s1;
	logic [SPAN_BITS-1:0] span_s1;
	logic [SPAN_BITS-1:0] step_s1;
	logic [CH_W-1:0]      adiff_s1 [CH_N];

	logic [CH_N-1:0]      neg;
	logic [CH_W-1:0]      adiff [CH_N];

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			neg[c] = colour_end[c*CH_W +: CH_W] < colour_start[c*CH_W +: CH_W];
			adiff[c] = neg[c]
				? colour_start[c*CH_W +: CH_W] - colour_end[c*CH_W +: CH_W]
				: colour_end[c*CH_W +: CH_W] - colour_start[c*CH_W +: CH_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.colour_start <= colour_start;
			side_s1.neg          <= neg;
			side_s1.span_zero    <= span_length == '0;
			span_s1              <= span_length;
			step_s1              <= step_index;
			adiff_s1             <= adiff;
			side_s2              <= side_s1;
			span_s2              <= span_s1;
			for (int c = 0; c < CH_N; c++) begin
				mag_s2[c] <= DW'(adiff_s1[c]) * DW'(step_s1);
			end
		end
	end

endmodule

/* hw/rtl/acri_div_stage.sv */
// one stage of the restoring divider, NSTEPS quotient bits for each channel
module acri_div_stage import acri_pkg::*; #(
	parameter int SPAN_BITS = SPAN_BITS_DEF,
	parameter int NSTEPS    = DIV_STEPS,
	localparam int DW = CH_W + SPAN_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid,
	input  side_t                side,
	input  logic [SPAN_BITS-1:0] span,
	input  logic [SPAN_BITS-1:0] rem [CH_N],
	input  logic [DW-1:0]        quo [CH_N],
	output logic                 valid_q,
	output side_t                side_q,
	output logic [SPAN_BITS-1:0] span_q,
	output logic [SPAN_BITS-1:0] rem_q [CH_N],
	output logic [DW-1:0]        quo_q [CH_N]
);

	logic [SPAN_BITS-1:0] rem_nx [CH_N];
	logic [DW-1:0]        quo_nx [CH_N];

	// dividend bits shift out of the top of quo, quotient bits shift in at the bottom
	always_comb begin
		logic [SPAN_BITS:0]   t;
		logic [SPAN_BITS-1:0] r;
		logic [DW-1:0]        d;
		for (int c = 0; c < CH_N; c++) begin
			r = rem[c];
			d = quo[c];
			for (int i = 0; i < NSTEPS; i++) begin
				t = {r, d[DW-1]};
				d = {d[DW-2:0], 1'b0};
				if (t >= {1'b0, span}) begin
					t = t - {1'b0, span};
					d[0] = 1'b1;
				end
				r = t[SPAN_BITS-1:0];
			end
			rem_nx[c] = r;
			quo_nx[c] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side;
			span_q <= span;
			rem_q  <= rem_nx;
			quo_q  <= quo_nx;
		end
	end

endmodule

/* hw/rtl/argb_colour_ramp_interpolator.sv */
// Per-channel linear ARGB8888 ramp: start + ((end - start) * step) / span for each channel,
// division truncating toward zero, channels wrapped to 8 bits, zero span passes the start
// colour through. One request enters per cycle unless the pipeline holds; the whole
// pipeline holds while a finished result waits at the output. The restoring divider yields
// four quotient bits per stage, fewer in the last when 8 + SPAN_BITS is not a multiple of 4.
module argb_colour_ramp_interpolator import acri_pkg::*; #(
	parameter int SPAN_BITS = SPAN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	acri_in_if.sink     in_ch,
	acri_out_if.source  out_ch
);

	localparam int DW  = CH_W + SPAN_BITS;
	localparam int NST = (DW + DIV_STEPS - 1) / DIV_STEPS;

	logic                 en;
	logic                 valid_q;
	logic [COLOUR_W-1:0]  colour_q;

	logic                 d_valid [NST+1];
	side_t                d_side  [NST+1];
	logic [SPAN_BITS-1:0] d_span  [NST+1];
	logic [SPAN_BITS-1:0] d_rem   [NST+1][CH_N];
	logic [DW-1:0]        d_quo   [NST+1][CH_N];

	logic [COLOUR_W-1:0]  colour_nx;

	assign en          = !valid_q || out_ch.ready;
	assign in_ch.ready = en;

	acri_front #(.SPAN_BITS(SPAN_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid        (in_ch.valid),
		.colour_start (in_ch.colour_start),
		.colour_end   (in_ch.colour_end),
		.span_length  (in_ch.span_length),
		.step_index   (in_ch.step_index),
		.valid_s2     (d_valid[0]),
		.side_s2      (d_side[0]),
		.span_s2      (d_span[0]),
		.mag_s2       (d_quo[0])
	);

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			d_rem[0][c] = '0;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_div
		localparam int STEPS = (DW - k * DIV_STEPS < DIV_STEPS) ? DW - k * DIV_STEPS : DIV_STEPS;
		acri_div_stage #(.SPAN_BITS(SPAN_BITS), .NSTEPS(STEPS)) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.valid   (d_valid[k]),
			.side    (d_side[k]),
			.span    (d_span[k]),
			.rem     (d_rem[k]),
			.quo     (d_quo[k]),
			.valid_q (d_valid[k+1]),
			.side_q  (d_side[k+1]),
			.span_q  (d_span[k+1]),
			.rem_q   (d_rem[k+1]),
			.quo_q   (d_quo[k+1])
		);
	end

	// only the low byte of the quotient survives the wrap
	always_comb begin
		logic [CH_W-1:0] a;
		logic [CH_W-1:0] q;
		for (int c = 0; c < CH_N; c++) begin
			a = d_side[NST].colour_start[c*CH_W +: CH_W];
			q = d_quo[NST][c][CH_W-1:0];
			colour_nx[c*CH_W +: CH_W] = d_side[NST].neg[c] ? a - q : a + q;
		end
		if (d_side[NST].span_zero) begin
			colour_nx = d_side[NST].colour_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= d_valid[NST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			colour_q <= colour_nx;
		end
	end

	assign out_ch.valid      = valid_q;
	assign out_ch.colour_out = colour_q;

endmodule

/* hw/rtl/acri_chk.sv */
// port-level checks of the colour ramp interpolator, bound to the top level
module acri_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] colour_out
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(colour_out))
		else $error("result changed while stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused with empty output");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while pipeline held");

endmodule

bind argb_colour_ramp_interpolator acri_chk u_acri_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.colour_out (out_ch.colour_out)
);
